### design/im2col_pkg.sv
// Shared types and constants for the im2col address generator.
// Holds the item, config and queue-entry structs and the register index codes.
// No dependencies.
package im2col_pkg;

	// field widths fixed by the interface
	localparam int ROW_W    = 10;
	localparam int DIM_W    = 11;
	localparam int KER_W    = 4;
	localparam int STRIDE_W = 4;
	localparam int PAD_W    = 3;
	localparam int TAP_W    = 3;
	localparam int ADDR_W   = 26;

	// row*stride or col*stride: 1023*15 fits in 14 bits
	localparam int BASE_W   = ROW_W + STRIDE_W;
	// pixel index h*W+w for in-range taps: below 2^22
	localparam int PIX_W    = 2 * DIM_W;

	// position queue between front and back
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);

	// config register indexes
	typedef enum logic [2:0] {
		REG_IN_HEIGHT = 3'd0,
		REG_IN_WIDTH  = 3'd1,
		REG_KERNEL_H  = 3'd2,
		REG_KERNEL_W  = 3'd3,
		REG_STRIDE_H  = 3'd4,
		REG_STRIDE_W  = 3'd5,
		REG_PAD_TOP   = 3'd6,
		REG_LEFT_PAD  = 3'd7
	} cfg_index_t;

	typedef struct packed {
		logic [ROW_W-1:0] out_row;
		logic [ROW_W-1:0] out_col;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] element_base;
		logic              is_padding;
		logic [TAP_W-1:0]  tap_row;
		logic [TAP_W-1:0]  tap_col;
		logic              last;
	} out_item_t;

	// configuration as seen by the back end (kernel sizes already clamped)
	typedef struct packed {
		logic [DIM_W-1:0] in_height;
		logic [DIM_W-1:0] in_width;
		logic [KER_W-1:0] kh;
		logic [KER_W-1:0] kw;
		logic [PAD_W-1:0] pad_top;
		logic [PAD_W-1:0] left_pad;
	} back_cfg_t;

	// one queued output position, already scaled by the strides
	typedef struct packed {
		logic [BASE_W-1:0] row_base;
		logic [BASE_W-1:0] col_base;
	} pos_t;

endpackage

### design/im2col_front.sv
// Front end: takes output positions and scales them by the strides.
// Depends on im2col_pkg.
module im2col_front
	import im2col_pkg::*;
(
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_item,
	input  logic [STRIDE_W-1:0] stride_h,
	input  logic [STRIDE_W-1:0] stride_w,
	input  logic                q_full,
	output logic                push,
	output pos_t                push_pos
);

	// accept whenever the queue has room
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// row*stride_h and col*stride_w, 10x4 products
	assign push_pos.row_base = BASE_W'(in_item.out_row * stride_h);
	assign push_pos.col_base = BASE_W'(in_item.out_col * stride_w);

endmodule

### design/im2col_queue.sv
// Short position queue that decouples front and back ends.
// Depends on im2col_pkg.
module im2col_queue
	import im2col_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pos_t push_pos,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output pos_t head_pos
);

	pos_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_pos   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_pos;
		end
	end

endmodule

### design/im2col_back.sv
// Back end: walks the kernel taps of the head position, one tap per cycle unless
// the output is stalled, through a three-stage address pipeline. Depends on im2col_pkg.
module im2col_back
	import im2col_pkg::*;
#(
	parameter int CHANNELS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  back_cfg_t cfg,
	input  logic      head_valid,
	input  pos_t      head_pos,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	localparam int CH_W = $clog2(CHANNELS + 1);
	localparam logic [CH_W-1:0] CH_MUL = CH_W'(CHANNELS);

	logic             advance;
	logic             last_tap;
	logic [TAP_W-1:0] p_q;
	logic [TAP_W-1:0] q_q;

	logic signed [BASE_W:0] h_in;
	logic signed [BASE_W:0] w_in;
	logic                   h_ok;
	logic                   w_ok;

	// stage 1: tap coordinates and range check
	logic             valid_s1;
	logic [DIM_W-1:0] h_s1;
	logic [DIM_W-1:0] w_s1;
	logic             ok_s1;
	logic [TAP_W-1:0] p_s1;
	logic [TAP_W-1:0] q_s1;
	logic             last_s1;

	// stage 2: pixel index
	logic             valid_s2;
	logic [PIX_W-1:0] pix_s2;
	logic             ok_s2;
	logic [TAP_W-1:0] p_s2;
	logic [TAP_W-1:0] q_s2;
	logic             last_s2;

	// stage 3: output register
	logic      valid_s3;
	out_item_t item_s3;

	logic [PIX_W+CH_W-1:0] addr_full;

	// whole pipeline moves unless the output holds a stalled item
	assign advance  = !(valid_s3 && out_stall);
	assign last_tap = ({1'b0, p_q} == cfg.kh - 1'b1) && ({1'b0, q_q} == cfg.kw - 1'b1);
	assign pop      = advance && head_valid && last_tap;

	// tap sequencer, q inner, p outer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
			q_q <= '0;
		end else if (advance && head_valid) begin
			if ({1'b0, q_q} == cfg.kw - 1'b1) begin
				q_q <= '0;
				p_q <= last_tap ? '0 : p_q + 1'b1;
			end else begin
				q_q <= q_q + 1'b1;
			end
		end
	end

	// input coordinates of this tap, signed after padding offset
	assign h_in = $signed({1'b0, head_pos.row_base}) + $signed({{(BASE_W-TAP_W+1){1'b0}}, p_q})
		- $signed({{(BASE_W-PAD_W+1){1'b0}}, cfg.pad_top});
	assign w_in = $signed({1'b0, head_pos.col_base}) + $signed({{(BASE_W-TAP_W+1){1'b0}}, q_q})
		- $signed({{(BASE_W-PAD_W+1){1'b0}}, cfg.left_pad});
	assign h_ok = !h_in[BASE_W] && (h_in[BASE_W-1:0] < BASE_W'(cfg.in_height));
	assign w_ok = !w_in[BASE_W] && (w_in[BASE_W-1:0] < BASE_W'(cfg.in_width));

	assign addr_full = pix_s2 * CH_MUL;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= head_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (advance) begin
			h_s1    <= h_in[DIM_W-1:0];
			w_s1    <= w_in[DIM_W-1:0];
			ok_s1   <= h_ok && w_ok;
			p_s1    <= p_q;
			q_s1    <= q_q;
			last_s1 <= last_tap;

			pix_s2  <= PIX_W'(h_s1) * PIX_W'(cfg.in_width) + PIX_W'(w_s1);
			ok_s2   <= ok_s1;
			p_s2    <= p_s1;
			q_s2    <= q_s1;
			last_s2 <= last_s1;

			item_s3.element_base <= ok_s2 ? ADDR_W'(addr_full) : '0;
			item_s3.is_padding   <= !ok_s2;
			item_s3.tap_row      <= p_s2;
			item_s3.tap_col      <= q_s2;
			item_s3.last         <= last_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

### design/im2col_address_generator.sv
// im2col address generator: one result per kernel tap, kernel_h*kernel_w per
// position (9 for 3x3), one tap per cycle from the back end's sequencer unless the
// output stalls. Accepted positions pass the queue and back-end stages 1, 2 and 3;
// a 2-entry queue lets the next positions be taken while the current one is walked.
// Reset clears the queue, tap counters and pipeline valids; config registers
// return to sizes and strides of 1 and pads of 0.
module im2col_address_generator
	import im2col_pkg::*;
#(
	parameter int CHANNELS   = 64,
	parameter int MAX_KERNEL = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cfg_index_t       cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	logic [DIM_W-1:0]    in_height_q;
	logic [DIM_W-1:0]    in_width_q;
	logic [KER_W-1:0]    kernel_h_q;
	logic [KER_W-1:0]    kernel_w_q;
	logic [STRIDE_W-1:0] stride_h_q;
	logic [STRIDE_W-1:0] stride_w_q;
	logic [PAD_W-1:0]    pad_top_q;
	logic [PAD_W-1:0]    left_pad_q;

	back_cfg_t bcfg;
	logic      push;
	pos_t      push_pos;
	logic      q_full;
	logic      head_valid;
	pos_t      head_pos;
	logic      pop;

	assign cfg_ready = 1'b1;

	// config register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q <= DIM_W'(1);
			in_width_q  <= DIM_W'(1);
			kernel_h_q  <= KER_W'(1);
			kernel_w_q  <= KER_W'(1);
			stride_h_q  <= STRIDE_W'(1);
			stride_w_q  <= STRIDE_W'(1);
			pad_top_q   <= '0;
			left_pad_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IN_HEIGHT: in_height_q <= cfg_data;
				REG_IN_WIDTH:  in_width_q  <= cfg_data;
				REG_KERNEL_H:  kernel_h_q  <= cfg_data[KER_W-1:0];
				REG_KERNEL_W:  kernel_w_q  <= cfg_data[KER_W-1:0];
				REG_STRIDE_H:  stride_h_q  <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_W:  stride_w_q  <= cfg_data[STRIDE_W-1:0];
				REG_PAD_TOP:   pad_top_q   <= cfg_data[PAD_W-1:0];
				REG_LEFT_PAD:  left_pad_q  <= cfg_data[PAD_W-1:0];
				default: ;
			endcase
		end
	end

	// kernel sizes: zero acts as one, large values saturate
	always_comb begin
		bcfg.in_height = in_height_q;
		bcfg.in_width  = in_width_q;
		bcfg.pad_top   = pad_top_q;
		bcfg.left_pad  = left_pad_q;
		if (kernel_h_q == '0) begin
			bcfg.kh = KER_W'(1);
		end else if (kernel_h_q > KER_W'(MAX_KERNEL)) begin
			bcfg.kh = KER_W'(MAX_KERNEL);
		end else begin
			bcfg.kh = kernel_h_q;
		end
		if (kernel_w_q == '0) begin
			bcfg.kw = KER_W'(1);
		end else if (kernel_w_q > KER_W'(MAX_KERNEL)) begin
			bcfg.kw = KER_W'(MAX_KERNEL);
		end else begin
			bcfg.kw = kernel_w_q;
		end
	end

	im2col_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.stride_h (stride_h_q),
		.stride_w (stride_w_q),
		.q_full   (q_full),
		.push     (push),
		.push_pos (push_pos)
	);

	im2col_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_pos   (push_pos),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_pos   (head_pos)
	);

	im2col_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (bcfg),
		.head_valid (head_valid),
		.head_pos   (head_pos),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule
